FILE: hw/rtl/pmd_pkg.sv
// Shared types, constants and helpers for the position PID motor drive.
package pmd_pkg;

    localparam int DUTY_BITS = 16;
    localparam logic [24:0] DUTY_TOP = (25'd1 << DUTY_BITS) - 25'd1;

    localparam int IN_TDATA_W  = 72;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int STEP_W     = 3;
    localparam int DIV_DIGITS = 5;
    localparam int MAC_STEPS  = 6;

    localparam logic [24:0] DIV_RECIP = 25'd1456;
    localparam logic [13:0] DIVISOR   = 14'd45;

    typedef enum logic [2:0] {
        REQ_ENCODER   = 3'd0,
        REQ_TARGET    = 3'd1,
        REQ_DUTY      = 3'd2,
        REQ_DIRECTION = 3'd3,
        REQ_INIT      = 3'd4
    } req_kind_t;

    typedef enum logic [1:0] {
        DIR_OFF    = 2'd0,
        DIR_CW     = 2'd1,
        DIR_CCW    = 2'd2,
        DIR_IGNORE = 2'd3
    } dir_code_t;

    typedef enum logic [2:0] {
        CFG_GAIN_PROP  = 3'd0,
        CFG_GAIN_INTEG = 3'd1,
        CFG_GAIN_DERIV = 3'd2,
        CFG_CPR        = 3'd3,
        CFG_MAX_SPEED  = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPLY,
        ST_PROD,
        ST_DIV_INIT,
        ST_DIV,
        ST_ERR,
        ST_MAC,
        ST_CLAMP,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic              load;
        logic              apply;
        logic              mul;
        logic              div_init;
        logic              div_step;
        logic              err;
        logic              mac_mul;
        logic              mac_acc;
        logic [STEP_W-1:0] mac_idx;
        logic              clamp;
        logic              out_load;
    } pmd_cmd_t;

    typedef struct packed {
        logic is_target;
        logic out_busy;
    } pmd_status_t;

    function automatic logic [DUTY_BITS-1:0] sat_duty(input logic [15:0] v);
        logic [24:0] wide;
        wide = {9'd0, v};
        if (wide > DUTY_TOP)
            return DUTY_TOP[DUTY_BITS-1:0];
        else
            return wide[DUTY_BITS-1:0];
    endfunction

endpackage

FILE: hw/rtl/pmd_ctrl.sv
// Sequencing state machine for the motor drive: issues datapath commands per request.
module pmd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  pmd_pkg::pmd_status_t status,
    output pmd_pkg::pmd_cmd_t    cmd
);

    pmd_pkg::ctrl_state_t              state_reg, state_next;
    logic [pmd_pkg::STEP_W-1:0]        step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pmd_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            pmd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid)
                    state_next = pmd_pkg::ST_APPLY;
            end
            pmd_pkg::ST_APPLY:
            begin
                if (status.is_target)
                    state_next = pmd_pkg::ST_PROD;
                else
                begin
                    cmd.apply  = 1'b1;
                    state_next = pmd_pkg::ST_OUT;
                end
            end
            pmd_pkg::ST_PROD:
            begin
                cmd.mul    = 1'b1;
                state_next = pmd_pkg::ST_DIV_INIT;
            end
            pmd_pkg::ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = pmd_pkg::ST_DIV;
            end
            pmd_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == pmd_pkg::STEP_W'(pmd_pkg::DIV_DIGITS - 1))
                begin
                    step_next  = '0;
                    state_next = pmd_pkg::ST_ERR;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            pmd_pkg::ST_ERR:
            begin
                cmd.err    = 1'b1;
                step_next  = '0;
                state_next = pmd_pkg::ST_MAC;
            end
            pmd_pkg::ST_MAC:
            begin
                cmd.mac_idx = step_reg;
                cmd.mac_mul = (step_reg < pmd_pkg::STEP_W'(pmd_pkg::MAC_STEPS));
                cmd.mac_acc = (step_reg != '0);
                if (step_reg == pmd_pkg::STEP_W'(pmd_pkg::MAC_STEPS))
                begin
                    step_next  = '0;
                    state_next = pmd_pkg::ST_CLAMP;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            pmd_pkg::ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = pmd_pkg::ST_OUT;
            end
            pmd_pkg::ST_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = pmd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pmd_pkg::ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/pmd_datapath.sv
// Datapath of the motor drive: config registers, target divider, PID multiply-accumulate, output.
module pmd_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pmd_pkg::pmd_cmd_t                   cmd,
    output pmd_pkg::pmd_status_t                status,
    input  logic [pmd_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic [pmd_pkg::IN_TUSER_W-1:0]      s_tuser,
    input  logic                                cfg_valid,
    input  logic [pmd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pmd_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pmd_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    // configuration
    logic signed [31:0] gain_prop_reg, gain_integ_reg, gain_deriv_reg;
    logic [23:0]        cpr_reg;
    logic [15:0]        max_speed_reg;

    // latched request
    logic [2:0]         kind_reg;
    logic signed [31:0] enc_reg;
    logic signed [20:0] angle_reg;
    logic [15:0]        speed_reg;
    logic [1:0]         dir_reg;

    // architectural state
    logic signed [31:0] position_reg;
    logic signed [47:0] integral_reg;
    logic signed [33:0] prev_err_reg;
    logic [pmd_pkg::DUTY_BITS-1:0] duty_reg;
    logic               phase_reg;
    logic signed [16:0] last_ctl_reg;

    // working registers
    logic signed [45:0] prod_reg;
    logic               neg_reg;
    logic [39:0]        dividend_reg;
    logic [39:0]        quot_reg;
    logic [5:0]         rem_reg;
    logic signed [34:0] deriv_reg;
    logic signed [56:0] mprod_reg;
    logic               mhi_reg;
    logic signed [81:0] acc_reg;

    logic               out_valid_reg;
    logic [pmd_pkg::OUT_TDATA_W-1:0] out_data_reg;

    // divider digit
    logic [45:0] prod_mag;
    logic [13:0] div_v;
    logic [24:0] div_p;
    logic [7:0]  div_qe;
    logic [13:0] div_qm;
    logic [13:0] div_r;
    logic [7:0]  div_q;
    logic [5:0]  div_rem;

    // error update
    logic signed [28:0] target;
    logic signed [33:0] err;
    logic signed [48:0] integ_wide;
    logic signed [47:0] integ_sat;
    logic signed [34:0] deriv;

    // multiply-accumulate
    logic signed [24:0] mac_b;
    logic signed [31:0] mac_k;
    logic signed [81:0] mac_term;
    logic signed [81:0] mac_shifted;

    // clamp
    logic signed [81:0] lim;
    logic               clamp_hi, clamp_lo;
    logic [33:0]        rnd;
    logic signed [16:0] ctl;
    logic signed [16:0] ctl_neg;
    logic [15:0]        ctl_mag;

    logic [24:0]        duty_wide;

    assign status.is_target = (kind_reg == pmd_pkg::REQ_TARGET);
    assign status.out_busy  = out_valid_reg && !m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg  <= '0;
            gain_integ_reg <= '0;
            gain_deriv_reg <= '0;
            cpr_reg        <= 24'd256;
            max_speed_reg  <= 16'd4095;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pmd_pkg::CFG_GAIN_PROP:  gain_prop_reg  <= cfg_data;
                pmd_pkg::CFG_GAIN_INTEG: gain_integ_reg <= cfg_data;
                pmd_pkg::CFG_GAIN_DERIV: gain_deriv_reg <= cfg_data;
                pmd_pkg::CFG_CPR:        cpr_reg        <= cfg_data[23:0];
                pmd_pkg::CFG_MAX_SPEED:  max_speed_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= s_tuser;
            enc_reg   <= s_tdata[31:0];
            angle_reg <= s_tdata[52:32];
            speed_reg <= s_tdata[68:53];
            dir_reg   <= s_tdata[70:69];
        end
    end

    always_comb
    begin
        prod_mag = prod_reg[45] ? 46'(-prod_reg) : 46'(prod_reg);
        div_v    = {rem_reg, dividend_reg[39:32]};
        div_p    = {11'd0, div_v} * pmd_pkg::DIV_RECIP;
        div_qe   = div_p[23:16];
        div_qm   = {6'd0, div_qe} * pmd_pkg::DIVISOR;
        div_r    = div_v - div_qm;
        if (div_r >= pmd_pkg::DIVISOR)
        begin
            div_q   = div_qe + 8'd1;
            div_rem = 6'(div_r - pmd_pkg::DIVISOR);
        end
        else
        begin
            div_q   = div_qe;
            div_rem = div_r[5:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            prod_reg <= angle_reg * $signed({1'b0, cpr_reg});
        if (cmd.div_init)
        begin
            neg_reg      <= prod_reg[45];
            dividend_reg <= {7'd0, prod_mag[43:11]};
            quot_reg     <= '0;
            rem_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            dividend_reg <= {dividend_reg[31:0], 8'd0};
            quot_reg     <= {quot_reg[31:0], div_q};
            rem_reg      <= div_rem;
        end
    end

    always_comb
    begin
        target     = neg_reg ? -$signed({1'b0, quot_reg[27:0]}) : $signed({1'b0, quot_reg[27:0]});
        err        = 34'(target) - 34'(position_reg);
        integ_wide = 49'(integral_reg) + 49'(err);
        if (integ_wide[48] != integ_wide[47])
            integ_sat = integ_wide[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        else
            integ_sat = integ_wide[47:0];
        deriv      = 35'(err) - 35'(prev_err_reg);
    end

    always_comb
    begin
        case (cmd.mac_idx)
            3'd0:    mac_b = $signed({1'b0, prev_err_reg[23:0]});
            3'd1:    mac_b = 25'($signed(prev_err_reg[33:24]));
            3'd2:    mac_b = $signed({1'b0, integral_reg[23:0]});
            3'd3:    mac_b = 25'($signed(integral_reg[47:24]));
            3'd4:    mac_b = $signed({1'b0, deriv_reg[23:0]});
            3'd5:    mac_b = 25'($signed(deriv_reg[34:24]));
            default: mac_b = '0;
        endcase
        case (cmd.mac_idx[2:1])
            2'd0:    mac_k = gain_prop_reg;
            2'd1:    mac_k = gain_integ_reg;
            2'd2:    mac_k = gain_deriv_reg;
            default: mac_k = '0;
        endcase
        mac_term    = 82'(mprod_reg);
        mac_shifted = mhi_reg ? {mac_term[57:0], 24'd0} : mac_term;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac_mul)
        begin
            mprod_reg <= mac_k * mac_b;
            mhi_reg   <= cmd.mac_idx[0];
        end
        if (cmd.err)
        begin
            acc_reg   <= '0;
            deriv_reg <= deriv;
        end
        else if (cmd.mac_acc)
            acc_reg <= acc_reg + mac_shifted;
    end

    always_comb
    begin
        lim      = $signed({50'd0, max_speed_reg, 16'd0});
        clamp_hi = (acc_reg >= lim);
        clamp_lo = (acc_reg <= -lim);
        rnd      = acc_reg[33:0] + (acc_reg[81] ? 34'd65535 : 34'd0);
        if (clamp_hi)
            ctl = $signed({1'b0, max_speed_reg});
        else if (clamp_lo)
            ctl = -$signed({1'b0, max_speed_reg});
        else
            ctl = $signed(rnd[32:16]);
        ctl_neg = -ctl;
        ctl_mag = ctl[16] ? ctl_neg[15:0] : ctl[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            integral_reg <= '0;
            prev_err_reg <= '0;
            duty_reg     <= '0;
            phase_reg    <= 1'b0;
            last_ctl_reg <= '0;
        end
        else if (cmd.apply)
        begin
            case (kind_reg)
                pmd_pkg::REQ_ENCODER: position_reg <= enc_reg;
                pmd_pkg::REQ_DUTY:    duty_reg     <= pmd_pkg::sat_duty(speed_reg);
                pmd_pkg::REQ_DIRECTION:
                begin
                    case (dir_reg)
                        pmd_pkg::DIR_OFF: duty_reg  <= '0;
                        pmd_pkg::DIR_CW:  phase_reg <= 1'b1;
                        pmd_pkg::DIR_CCW: phase_reg <= 1'b0;
                        default: ;
                    endcase
                end
                pmd_pkg::REQ_INIT:    duty_reg     <= '0;
                default: ;
            endcase
        end
        else if (cmd.err)
        begin
            integral_reg <= integ_sat;
            prev_err_reg <= err;
        end
        else if (cmd.clamp)
        begin
            last_ctl_reg <= ctl;
            if (ctl[16])
            begin
                phase_reg <= 1'b0;
                duty_reg  <= pmd_pkg::sat_duty(ctl_mag);
            end
            else if (ctl != '0)
            begin
                phase_reg <= 1'b1;
                duty_reg  <= pmd_pkg::sat_duty(ctl_mag);
            end
            else
                duty_reg <= '0;
        end
    end

    assign duty_wide = 25'(duty_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_data_reg <= {6'd0, last_ctl_reg, phase_reg, duty_wide[15:0]};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: hw/rtl/pid_position_motor_drive.sv
// Top level of the position PID motor drive: controller plus datapath.
//
// Requests arrive on the s_ stream: s_tuser carries the request kind, s_tdata the
// encoder count, target angle, duty value and direction code. Each accepted request
// yields exactly one result transfer on the m_ stream with duty, phase level and
// the last clamped control value.
// The block handles one request at a time. Encoder, duty, direction and init
// requests pass through apply, then the output register load. A target angle
// passes through decode, one multiply for the target counts, divider setup, five
// digit steps of the divide by 45, the error update, the shared 32x25
// multiply-accumulate, the clamp and the output load. The next request can
// transfer at the edge after m_tvalid rises.
// The output register holds a result while m_tready is low; the next request is
// still taken and worked on, and waits at the end only if the previous result has
// not been taken. Configuration writes on the cfg_ channel are always ready and
// take effect in the next cycle; write them while the block is idle.
// Reset clears the gains, sets counts per revolution to 1.0 and max speed to 4095,
// and clears position, integral, previous error, duty, phase and control.
module pid_position_motor_drive (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // encoder_count[31:0], angle_deg[52:32], speed_value[68:53], direction_code[70:69]
    input  logic [pmd_pkg::IN_TDATA_W-1:0]      s_tdata,
    // req_type[2:0]
    input  logic [pmd_pkg::IN_TUSER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // duty[15:0], phase_level[16], control_signal[33:17]
    output logic [pmd_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pmd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pmd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    pmd_pkg::pmd_cmd_t    cmd;
    pmd_pkg::pmd_status_t status;

    assign cfg_ready = 1'b1;

    pmd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pmd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: hw/rtl/pmd_checker.sv
// Port-level checks for the motor drive and their binding to the top level.
module pmd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [pmd_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in flight");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early after request transfer");

endmodule

bind pid_position_motor_drive pmd_checker u_pmd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
